/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Check that a condition leads to a consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hdl/gctg_pkg.sv */
// ----------------------------------------------------------------------------
// gctg_pkg
// Sizes, register indexes, stage types and the quarter-wave sine ROM
// contents for the gated quadrature tone generator.
// ----------------------------------------------------------------------------
package gctg_pkg;

  // Datapath sizes
  localparam int PHASE_BITS  = 32;
  localparam int TABLE_BITS  = 10;
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 32;
  localparam int POS_BITS    = 16;
  localparam int AMP_BITS    = 16;
  localparam int BLOCK_BITS  = 17;
  localparam int MAX_BLOCK   = 65536;

  // Quarter-wave ROM geometry
  localparam int QUARTER    = 1 << (TABLE_BITS - 2);
  localparam int QADDR_BITS = TABLE_BITS - 1;
  localparam int MAG_BITS   = SAMPLE_BITS - 1;
  localparam int PEAK       = (1 << (SAMPLE_BITS - 1)) - 1;

  // Scaling: Q1.15 gain, round half up
  localparam int FRAC_BITS = AMP_BITS - 1;
  localparam int PROD_BITS = MAG_BITS + AMP_BITS;

  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PHASE_INC   = 3'd0,
    REG_INIT_PHASE  = 3'd1,
    REG_AMPLITUDE   = 3'd2,
    REG_START_INDEX = 3'd3,
    REG_STOP_INDEX  = 3'd4,
    REG_TOTAL_COUNT = 3'd5,
    REG_BLOCK_LEN   = 3'd6
  } cfg_reg_t;

  // Sideband carried alongside the ROM read
  typedef struct packed {
    logic                  sin_neg;
    logic                  cos_neg;
    logic                  on;
    logic                  last;
    logic                  finished;
    logic [COUNT_BITS-1:0] number;
  } side_t;

  typedef logic [MAG_BITS-1:0] qwave_t [QUARTER+1];

  // (a * b) >> 60 for Q60 operands below 4
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ah, al, bh, bl, mid;
    ah  = a >> 32;
    al  = a & 64'hFFFF_FFFF;
    bh  = b >> 32;
    bl  = b & 64'hFFFF_FFFF;
    mid = ah * bl + al * bh + ((al * bl) >> 32);
    return ((ah * bh) << 4) + (mid >> 28);
  endfunction

  // Unsigned quotient by shift and subtract, for building constants only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter wave of round(PEAK * sin) from a Q60 Taylor series
  function automatic qwave_t build_qwave();
    qwave_t      w;
    logic [63:0] step, x, x2, term, sum, div, scaled;
    step = HALF_PI_Q60 >> (TABLE_BITS - 2);
    for (int k = 0; k <= QUARTER; k++) begin
      x    = (k == QUARTER) ? HALF_PI_Q60 : step * 64'(k);
      x2   = mul_q60(x, x);
      term = x;
      sum  = x;
      for (int n = 1; n < 40; n++) begin
        if (term != 64'd0) begin
          div  = 64'((2 * n) * (2 * n + 1));
          term = udiv64(mul_q60(term, x2), div);
          if ((n & 1) != 0) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
      end
      scaled = ((sum >> 24) * 64'(PEAK) + (64'd1 << 35)) >> 36;
      w[k]   = MAG_BITS'(scaled);
    end
    return w;
  endfunction

  localparam qwave_t QWAVE = build_qwave();

endpackage

/* hdl/gated_complex_tone_generator.sv */
// ----------------------------------------------------------------------------
// gated_complex_tone_generator
// Phase accumulator, quarter-wave sine ROM and gain stage producing one
// gated complex sample per request.
// ----------------------------------------------------------------------------
// Usage: each request (restart bit) yields one complex sample, and the block
// takes one request per clock for as long as the output side drains. Stage
// one updates the counters and phase accumulator and reads sine and cosine
// magnitudes from a dual-read quarter-wave ROM with a registered output;
// stage two multiplies by the gain; stage three rounds, saturates and gates
// into the output register. Writing phase_increment or initial_phase reloads
// the accumulator from the sample count through a 32x32 multiply and an add,
// so the input stalls while the multiply and the add are pending. cfg_ready
// is always high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gated_complex_tone_generator (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [2:0]                             cfg_index,
  input  logic [31:0]                            cfg_data,
  // requests
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   restart,
  // samples
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [gctg_pkg::SAMPLE_BITS-1:0] in_phase,
  output logic signed [gctg_pkg::SAMPLE_BITS-1:0] quadrature,
  output logic [gctg_pkg::COUNT_BITS-1:0]         sample_number,
  output logic                                   tone_on,
  output logic                                   block_last,
  output logic                                   finished
);

  localparam gctg_pkg::qwave_t QwaveRom = gctg_pkg::QWAVE;
  localparam logic signed [gctg_pkg::PROD_BITS+1:0] RoundHalf =
    (gctg_pkg::PROD_BITS + 2)'(1 << (gctg_pkg::FRAC_BITS - 1));
  localparam logic signed [gctg_pkg::PROD_BITS+1:0] SatHi =
    (gctg_pkg::PROD_BITS + 2)'(gctg_pkg::PEAK);
  localparam logic signed [gctg_pkg::PROD_BITS+1:0] SatLo = -SatHi - 1;

  // Configuration registers
  logic [gctg_pkg::PHASE_BITS-1:0] phase_increment;
  logic [gctg_pkg::PHASE_BITS-1:0] initial_phase;
  logic [gctg_pkg::AMP_BITS-1:0]   amplitude;
  logic [gctg_pkg::COUNT_BITS-1:0] start_index;
  logic [gctg_pkg::COUNT_BITS-1:0] stop_index;
  logic [gctg_pkg::COUNT_BITS-1:0] total_count;
  logic [gctg_pkg::BLOCK_BITS-1:0] block_length;

  // Running state
  logic [gctg_pkg::COUNT_BITS-1:0] produced_count;
  logic [gctg_pkg::PHASE_BITS-1:0] phase_accumulator;
  logic [gctg_pkg::POS_BITS-1:0]   block_position;

  // Accumulator reload sequencing
  logic                            cfg_fire;
  logic                            phase_write;
  logic                            reload_mul;
  logic                            reload_add;
  logic [gctg_pkg::PHASE_BITS-1:0] reload_product;

  // Stage one: request decode
  logic                            in_fire;
  logic [gctg_pkg::COUNT_BITS-1:0] eff_count;
  logic [gctg_pkg::POS_BITS-1:0]   eff_pos;
  logic [gctg_pkg::PHASE_BITS-1:0] eff_acc;
  logic [gctg_pkg::BLOCK_BITS-1:0] len_m1;
  logic                            finished_now;
  logic                            on_now;
  logic                            last_now;
  logic [gctg_pkg::TABLE_BITS-1:0] sin_idx;
  logic [gctg_pkg::TABLE_BITS-1:0] cos_idx;
  logic [gctg_pkg::QADDR_BITS-1:0] sin_addr;
  logic [gctg_pkg::QADDR_BITS-1:0] cos_addr;

  // Pipeline registers and handshake
  logic                            s1_valid;
  gctg_pkg::side_t                 s1_side;
  logic [gctg_pkg::MAG_BITS-1:0]   sin_mag;
  logic [gctg_pkg::MAG_BITS-1:0]   cos_mag;
  logic                            s2_valid;
  gctg_pkg::side_t                 s2_side;
  logic [gctg_pkg::PROD_BITS-1:0]  sin_prod;
  logic [gctg_pkg::PROD_BITS-1:0]  cos_prod;
  logic                            out_free;
  logic                            s2_free;
  logic                            s1_free;

  // Round half up, shift by the gain fraction and saturate
  function automatic logic signed [gctg_pkg::SAMPLE_BITS-1:0] scale_mag(
    input logic [gctg_pkg::PROD_BITS-1:0] mag,
    input logic                           neg
  );
    logic signed [gctg_pkg::PROD_BITS+1:0] p;
    logic signed [gctg_pkg::PROD_BITS+1:0] r;
    p = $signed({2'b00, mag});
    if (neg) begin
      p = -p;
    end
    r = (p + RoundHalf) >>> gctg_pkg::FRAC_BITS;
    if (r > SatHi) begin
      r = SatHi;
    end else if (r < SatLo) begin
      r = SatLo;
    end
    return r[gctg_pkg::SAMPLE_BITS-1:0];
  endfunction

  // Handshake
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid || !out_stall;
  assign s2_free   = !s2_valid || out_free;
  assign s1_free   = !s1_valid || s2_free;
  assign in_stall  = !s1_free || reload_mul || reload_add;
  assign in_fire   = in_valid && !in_stall;

  assign phase_write = cfg_fire && (cfg_index == gctg_pkg::REG_PHASE_INC ||
                                    cfg_index == gctg_pkg::REG_INIT_PHASE);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_increment <= '0;
      initial_phase   <= '0;
      amplitude       <= gctg_pkg::AMP_BITS'(1 << gctg_pkg::FRAC_BITS);
      start_index     <= '0;
      stop_index      <= '0;
      total_count     <= '0;
      block_length    <= gctg_pkg::BLOCK_BITS'(gctg_pkg::MAX_BLOCK);
    end else if (cfg_fire) begin
      case (cfg_index)
        gctg_pkg::REG_PHASE_INC:   phase_increment <= cfg_data;
        gctg_pkg::REG_INIT_PHASE:  initial_phase   <= cfg_data;
        gctg_pkg::REG_AMPLITUDE:   amplitude       <= cfg_data[gctg_pkg::AMP_BITS-1:0];
        gctg_pkg::REG_START_INDEX: start_index     <= cfg_data;
        gctg_pkg::REG_STOP_INDEX:  stop_index      <= cfg_data;
        gctg_pkg::REG_TOTAL_COUNT: total_count     <= cfg_data;
        gctg_pkg::REG_BLOCK_LEN:   block_length    <= cfg_data[gctg_pkg::BLOCK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Sequence the reload: multiply, then add
  always_ff @(posedge clk) begin
    if (rst) begin
      reload_mul <= 1'b0;
      reload_add <= 1'b0;
    end else begin
      reload_mul <= phase_write;
      reload_add <= reload_mul;
    end
  end

  always_ff @(posedge clk) begin
    if (reload_mul) begin
      reload_product <= phase_increment * produced_count;
    end
  end

  // Apply restart and decide gating and block end
  always_comb begin
    eff_count = restart ? '0 : produced_count;
    eff_pos   = restart ? '0 : block_position;
    eff_acc   = restart ? initial_phase : phase_accumulator;

    if (block_length == '0) begin
      len_m1 = '0;
    end else if (block_length > gctg_pkg::BLOCK_BITS'(gctg_pkg::MAX_BLOCK)) begin
      len_m1 = gctg_pkg::BLOCK_BITS'(gctg_pkg::MAX_BLOCK - 1);
    end else begin
      len_m1 = block_length - 1'b1;
    end

    finished_now = eff_count >= total_count;
    on_now   = !finished_now && eff_count >= start_index &&
               (stop_index == '0 || eff_count < stop_index);
    last_now = !finished_now &&
               ({1'b0, eff_pos} >= len_m1 || eff_count == total_count - 1'b1);

    // Fold the table index onto the quarter wave
    sin_idx = eff_acc[gctg_pkg::PHASE_BITS-1 -: gctg_pkg::TABLE_BITS];
    cos_idx = sin_idx + gctg_pkg::TABLE_BITS'(gctg_pkg::QUARTER);
    sin_addr = {1'b0, sin_idx[gctg_pkg::TABLE_BITS-3:0]};
    cos_addr = {1'b0, cos_idx[gctg_pkg::TABLE_BITS-3:0]};
    if (sin_idx[gctg_pkg::TABLE_BITS-2]) begin
      sin_addr = gctg_pkg::QADDR_BITS'(gctg_pkg::QUARTER) - sin_addr;
    end
    if (cos_idx[gctg_pkg::TABLE_BITS-2]) begin
      cos_addr = gctg_pkg::QADDR_BITS'(gctg_pkg::QUARTER) - cos_addr;
    end
  end

  // Advance counters and phase; a reload wins over requests
  always_ff @(posedge clk) begin
    if (rst) begin
      produced_count    <= '0;
      block_position    <= '0;
      phase_accumulator <= '0;
    end else if (reload_add) begin
      phase_accumulator <= initial_phase + reload_product;
    end else if (in_fire) begin
      if (finished_now) begin
        produced_count    <= eff_count;
        block_position    <= eff_pos;
        phase_accumulator <= eff_acc;
      end else begin
        produced_count    <= eff_count + 1'b1;
        block_position    <= last_now ? '0 : eff_pos + 1'b1;
        phase_accumulator <= eff_acc + phase_increment;
      end
    end
  end

  // Read the ROM and capture the sideband
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sin_mag          <= QwaveRom[sin_addr];
      cos_mag          <= QwaveRom[cos_addr];
      s1_side.sin_neg  <= sin_idx[gctg_pkg::TABLE_BITS-1];
      s1_side.cos_neg  <= cos_idx[gctg_pkg::TABLE_BITS-1];
      s1_side.on       <= on_now;
      s1_side.last     <= last_now;
      s1_side.finished <= finished_now;
      s1_side.number   <= eff_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= in_fire;
    end
  end

  // Apply the gain
  always_ff @(posedge clk) begin
    if (s2_free && s1_valid) begin
      sin_prod <= sin_mag * amplitude;
      cos_prod <= cos_mag * amplitude;
      s2_side  <= s1_side;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  // Round, saturate and gate into the output register
  always_ff @(posedge clk) begin
    if (out_free && s2_valid) begin
      in_phase      <= s2_side.on ? scale_mag(cos_prod, s2_side.cos_neg) : '0;
      quadrature    <= s2_side.on ? scale_mag(sin_prod, s2_side.sin_neg) : '0;
      sample_number <= s2_side.number;
      tone_on       <= s2_side.on;
      block_last    <= s2_side.last;
      finished      <= s2_side.finished;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid;
    end
  end

  // Checks
  `ASSERT_ALWAYS(a_finished_zero, clk, rst,
    (out_valid && finished) |-> (in_phase == '0 && quadrature == '0 && !tone_on && !block_last))
  `ASSERT_ALWAYS(a_gated_zero, clk, rst,
    (out_valid && !tone_on) |-> (in_phase == '0 && quadrature == '0))
  `ASSERT_NEXT(a_reload_hold, clk, rst, phase_write, in_stall)
  `ASSERT_NEXT(a_count_step, clk, rst, in_fire && !restart && !finished_now,
    produced_count == $past(produced_count) + 32'd1)

endmodule
